// File: design/positional_array_list_unit_assert.svh
// Assertion macros for the positional array list unit.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define PAL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pal assertion failed");
// Next-cycle implication.
`define PAL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pal assertion failed");
`else
`define PAL_ASSERT_IMP(lbl, ante, cons)
`define PAL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/pal_pkg.sv
package pal_pkg;

	localparam int CAPACITY   = 128;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int FUNC_W     = 2;
	localparam int POS_W      = 7;
	localparam int ITEM_W     = 32;
	localparam int STAT_W     = 2;
	localparam int COUNT_W    = 8;
	localparam int GRP_SIZE   = 16;
	localparam int NUM_GRP    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [FUNC_W-1:0] {
		OP_READ   = 2'd0,
		OP_APPEND = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} pal_op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2
	} pal_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_GATHER
	} pal_state_t;

	typedef logic [DATA_WIDTH-1:0] pal_word_t;

	// Broadcast from the controller to every cell and the read tree.
	typedef struct packed {
		logic             do_ins;
		logic             do_del;
		logic             grp_en;
		logic [IDX_W-1:0] pos;
		pal_word_t        word;
	} pal_cell_ctl_t;

endpackage

// File: design/pal_req_if.sv
interface pal_req_if
	import pal_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  pos;
	logic signed [ITEM_W-1:0] item;

	modport source (output valid, output func, output pos, output item, input ready);
	modport sink   (input valid, input func, input pos, input item, output ready);
endinterface

// File: design/pal_rsp_if.sv
interface pal_rsp_if
	import pal_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic signed [ITEM_W-1:0] read_data;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] entry_count;
	logic               is_empty_flag;
	logic               is_full_flag;

	modport source (output valid, output read_data, output status, output entry_count,
		output is_empty_flag, output is_full_flag, input ready);
	modport sink   (input valid, input read_data, input status, input entry_count,
		input is_empty_flag, input is_full_flag, output ready);
endinterface

// File: design/pal_cell.sv
module pal_cell
	import pal_pkg::*;
(
	input  logic          clk,
	input  logic [IDX_W-1:0] idx,
	input  pal_cell_ctl_t ctl,
	input  pal_word_t     prev_word,
	input  pal_word_t     next_word,
	output pal_word_t     word,
	output pal_word_t     sel_word
);

	pal_word_t word_q;
	logic      at_or_above;
	logic      hit;

	assign hit         = (idx == ctl.pos);
	assign at_or_above = (idx >= ctl.pos);

	// Insert: take the left neighbor above the position, the new word at it.
	// Delete: take the right neighbor from the position up.
	always_ff @(posedge clk) begin
		if (ctl.do_ins && at_or_above) begin
			word_q <= hit ? ctl.word : prev_word;
		end else if (ctl.do_del && at_or_above) begin
			word_q <= next_word;
		end
	end

	assign word     = word_q;
	assign sel_word = hit ? word_q : '0;

endmodule

// File: design/pal_ctrl.sv
module pal_ctrl
	import pal_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pal_req_if.sink       req,
	pal_rsp_if.source     rsp,
	input  pal_word_t     rd_word,
	output pal_cell_ctl_t cell_ctl
);

	pal_state_t  state_q, state_d;
	pal_op_t     func_q;
	logic [POS_W-1:0] pos_q;
	pal_word_t   word_q;
	logic [CNT_W-1:0] count_q;
	pal_status_t stat_q, stat_d;
	logic        rd_en_q;
	logic        rsp_valid_q;
	logic signed [ITEM_W-1:0] rsp_data_q;
	pal_status_t rsp_stat_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic        rsp_empty_q, rsp_full_q;

	logic [CNT_W-1:0] pos_ext;
	logic        is_full;
	logic        accept;
	logic        do_ins, do_del;
	logic        exec, load_rsp;

	assign pos_ext = CNT_W'(pos_q);
	assign is_full = (count_q >= CNT_W'(CAPACITY));
	assign accept  = req.valid && req.ready;
	assign exec    = (state_q == S_EXEC);

	always_comb begin
		stat_d = STAT_DONE;
		case (func_q)
			OP_READ:   stat_d = (pos_ext < count_q) ? STAT_DONE : STAT_BADPOS;
			OP_APPEND: stat_d = is_full ? STAT_FULL : STAT_DONE;
			OP_INSERT: begin
				if (is_full) begin
					stat_d = STAT_FULL;
				end else if (pos_ext > count_q) begin
					stat_d = STAT_BADPOS;
				end
			end
			OP_DELETE: stat_d = (pos_ext < count_q) ? STAT_DONE : STAT_BADPOS;
			default:   stat_d = STAT_BADPOS;
		endcase
	end

	assign do_ins = exec && (stat_d == STAT_DONE)
		&& ((func_q == OP_APPEND) || (func_q == OP_INSERT));
	assign do_del = exec && (stat_d == STAT_DONE) && (func_q == OP_DELETE);

	// Append is an insert at the current count.
	always_comb begin
		cell_ctl.do_ins = do_ins;
		cell_ctl.do_del = do_del;
		cell_ctl.grp_en = exec;
		cell_ctl.pos    = (func_q == OP_APPEND) ? count_q[IDX_W-1:0] : IDX_W'(pos_q);
		cell_ctl.word   = word_q;
	end

	assign load_rsp = (state_q == S_GATHER) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = S_EXEC;
			end
			S_EXEC:   state_d = S_GATHER;
			S_GATHER: if (load_rsp) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_del) begin
				count_q <= count_q - 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= pal_op_t'(req.func);
			pos_q  <= req.pos;
			word_q <= req.item[DATA_WIDTH-1:0];
		end
		if (exec) begin
			stat_q  <= stat_d;
			rd_en_q <= (stat_d == STAT_DONE)
				&& ((func_q == OP_READ) || (func_q == OP_DELETE));
		end
		if (load_rsp) begin
			rsp_data_q  <= rd_en_q ? ITEM_W'($signed(rd_word)) : '0;
			rsp_stat_q  <= stat_q;
			rsp_count_q <= COUNT_W'(count_q);
			rsp_empty_q <= (count_q == '0);
			rsp_full_q  <= (count_q == CNT_W'(CAPACITY));
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_data     = rsp_data_q;
	assign rsp.status        = rsp_stat_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.is_empty_flag = rsp_empty_q;
	assign rsp.is_full_flag  = rsp_full_q;

endmodule

// File: design/positional_array_list_unit.sv
// Positional array list: an ordered, packed list of up to 128 signed 32-bit words.
// Request channel (req): func selects read, append, insert or delete; pos gives
// the list position for read, insert and delete; item is the word to store.
// Response channel (rsp): one transfer per request with the word read or removed,
// a status (done, position out of range, list full), the entry count after the
// operation and empty/full flags. A failed request leaves the list unchanged.
// Timing: a request is taken in the idle state; the cells update at the end of the
// execute state while a two-level OR tree with a registered first level selects the
// addressed word, and the response register loads in the gather state. A new request
// is taken only after the previous one has passed through the idle/execute/gather
// sequence of the controller.
// The response register holds a finished result while the next request is taken
// and executed; when the receiver stalls, the controller waits in gather until
// the response register frees up, and req.ready stays low meanwhile.
// Reset: the entry count clears to zero and the controller returns to idle with
// no response pending. The cell words are not cleared; only positions below the
// count are ever read.
module positional_array_list_unit
	import pal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pal_req_if.sink   req,
	pal_rsp_if.source rsp
);

`include "positional_array_list_unit_assert.svh"

	pal_cell_ctl_t cell_ctl;
	pal_word_t     cell_word [CAPACITY];
	pal_word_t     cell_sel  [CAPACITY];
	pal_word_t     grp_q     [NUM_GRP];
	pal_word_t     grp_d     [NUM_GRP];
	pal_word_t     rd_word;

	pal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rd_word  (rd_word),
		.cell_ctl (cell_ctl)
	);

	// Row of cells: each neighbor hands its word to the next for shifts.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pal_word_t prev_word, next_word;

		if (i == 0) begin : g_first
			assign prev_word = '0;
		end else begin : g_mid_lo
			assign prev_word = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_word = '0;
		end else begin : g_mid_hi
			assign next_word = cell_word[i+1];
		end

		pal_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctl       (cell_ctl),
			.prev_word (prev_word),
			.next_word (next_word),
			.word      (cell_word[i]),
			.sel_word  (cell_sel[i])
		);
	end

	// First tree level: OR the selected words of each group of cells and
	// hold the result; load only in the execute cycle, before the cells shift.
	for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_sel[g * GRP_SIZE + k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cell_ctl.grp_en) grp_q[g] <= grp_d[g];
		end
	end

	// Second tree level: merge the group results into the response register.
	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			rd_word = rd_word | grp_q[g];
		end
	end

	// The count reported can never pass the capacity.
	`PAL_ASSERT_IMP(a_count_max, rsp.valid, rsp.entry_count <= COUNT_W'(CAPACITY))
	// A full status is reported only with a full list.
	`PAL_ASSERT_IMP(a_full_status, rsp.valid && (rsp.status == STAT_FULL),
		rsp.is_full_flag && (rsp.entry_count == COUNT_W'(CAPACITY)))
	// A failed request returns a zero word.
	`PAL_ASSERT_IMP(a_err_zero, rsp.valid && (rsp.status != STAT_DONE), rsp.read_data == '0)
	// One request at a time: no transfer right after a transfer.
	`PAL_ASSERT_NXT(a_one_at_a_time, req.valid && req.ready, !req.ready)

endmodule

// File: dv/tb_positional_array_list_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the positional array list unit.
// A short stimulus table hits the edge cases first. Phases of random traffic
// follow: fill to capacity, drain to empty, and mixed requests. Every request
// transfer runs through a shadow copy of the list, and the predicted response
// is queued. Each response transfer is compared field by field with the
// oldest queued prediction.
module tb_positional_array_list_unit;
	import pal_pkg::*;

	localparam int RANDOM_REQUESTS = 1500;
	localparam int SQUEEZE_AT      = 500;   // responses checked before the long hold-off
	localparam int SQUEEZE_CYCLES  = 400;
	localparam int IDLE_LIMIT      = 3000;  // cycles with no transfer before giving up
	localparam int SETTLE_CYCLES   = 12;    // quiet time after the last response

	typedef struct {
		logic signed [ITEM_W-1:0] read_data;
		pal_status_t              status;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty_flag;
		logic                     is_full_flag;
	} list_result_t;

	typedef struct {
		pal_op_t                  op;
		logic [POS_W-1:0]         pos;
		logic signed [ITEM_W-1:0] word;
		bit                       known;
		list_result_t             want;
	} stim_row_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	logic clk;
	logic arst_n;

	pal_req_if req_ch ();
	pal_rsp_if rsp_ch ();

	positional_array_list_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the list contents and length.
	pal_word_t shadow_words [CAPACITY];
	int        shadow_len;

	list_result_t awaited_results [$];
	stim_row_t    stim_table [$];

	int  fail_count;
	int  checked_count;
	int  op_tally [4];
	int  badpos_tally;
	int  full_tally;
	int  at_capacity_tally;
	bit  sender_eager;
	bit  sink_eager;
	bit  squeeze_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow list and return the response it must give.
	function automatic list_result_t shadow_apply(input pal_op_t op, input logic [POS_W-1:0] p,
		input logic signed [ITEM_W-1:0] w);
		list_result_t r;
		int k;
		r.read_data = '0;
		r.status    = STAT_DONE;
		case (op)
			OP_READ: begin
				if (p < shadow_len)
					r.read_data = ITEM_W'($signed(shadow_words[p]));
				else
					r.status = STAT_BADPOS;
			end
			OP_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					shadow_words[shadow_len] = w[DATA_WIDTH-1:0];
					shadow_len++;
				end
			end
			OP_INSERT: begin
				// fullness wins over a bad position
				if (shadow_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else if (p > shadow_len) begin
					r.status = STAT_BADPOS;
				end else begin
					for (k = shadow_len; k > p; k--)
						shadow_words[k] = shadow_words[k-1];
					shadow_words[p] = w[DATA_WIDTH-1:0];
					shadow_len++;
				end
			end
			default: begin
				if (p < shadow_len) begin
					r.read_data = ITEM_W'($signed(shadow_words[p]));
					for (k = p; k + 1 < shadow_len; k++)
						shadow_words[k] = shadow_words[k+1];
					shadow_len--;
				end else begin
					r.status = STAT_BADPOS;
				end
			end
		endcase
		r.entry_count   = COUNT_W'(shadow_len);
		r.is_empty_flag = (shadow_len == 0);
		r.is_full_flag  = (shadow_len == CAPACITY);
		return r;
	endfunction

	function automatic void row_known(input pal_op_t op, input logic [POS_W-1:0] p,
		input logic signed [ITEM_W-1:0] w, input logic signed [ITEM_W-1:0] rd,
		input pal_status_t st, input logic [COUNT_W-1:0] cnt, input logic e, input logic f);
		stim_row_t r;
		r.op                 = op;
		r.pos                = p;
		r.word               = w;
		r.known              = 1'b1;
		r.want.read_data     = rd;
		r.want.status        = st;
		r.want.entry_count   = cnt;
		r.want.is_empty_flag = e;
		r.want.is_full_flag  = f;
		stim_table.push_back(r);
	endfunction

	function automatic void row_pred(input pal_op_t op, input logic [POS_W-1:0] p,
		input logic signed [ITEM_W-1:0] w);
		stim_row_t r;
		r.op    = op;
		r.pos   = p;
		r.word  = w;
		r.known = 1'b0;
		r.want  = '{default: '0, status: STAT_DONE};
		stim_table.push_back(r);
	endfunction

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [ITEM_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return $signed({1'b1, {(ITEM_W-1){1'b0}}});
			1: return $signed({1'b0, {(ITEM_W-1){1'b1}}});
			2: return '1;
			3: return '0;
			default: return $signed(ITEM_W'($urandom));
		endcase
	endfunction

	// Aim at valid positions most of the time; sometimes pick anything.
	function automatic logic [POS_W-1:0] pick_pos(input pal_op_t op);
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom);
		case (op)
			OP_READ, OP_DELETE: begin
				if (shadow_len == 0)
					return POS_W'($urandom);
				return POS_W'($urandom_range(0, shadow_len - 1));
			end
			OP_INSERT: begin
				if (shadow_len >= CAPACITY)
					return POS_W'($urandom);
				return POS_W'($urandom_range(0, shadow_len));
			end
			default: return POS_W'($urandom);
		endcase
	endfunction

	// Offer one request, hold it until the transfer, then queue its prediction.
	task automatic send_request(input pal_op_t op, input logic [POS_W-1:0] p,
		input logic signed [ITEM_W-1:0] w, input bit known, input list_result_t want);
		int gap;
		list_result_t model;
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= op;
		req_ch.pos   <= p;
		req_ch.item  <= w;
		do
			@(posedge clk);
		while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
		model = shadow_apply(op, p, w);
		awaited_results.push_back(known ? want : model);
		op_tally[op]++;
		if (model.status == STAT_BADPOS)
			badpos_tally++;
		if (model.status == STAT_FULL)
			full_tally++;
		if (model.is_full_flag)
			at_capacity_tally++;
	endtask

	task automatic send_random(input pal_op_t op);
		list_result_t none;
		none = '{default: '0, status: STAT_DONE};
		send_request(op, pick_pos(op), pick_word(), 1'b0, none);
	endtask

	// Response side: random stalls, stretches of steady ready, and one long
	// hold-off so the block backs up and drops req.ready.
	initial begin : sink_side
		int hold;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!squeeze_done && checked_count >= SQUEEZE_AT) begin
				squeeze_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				if ($urandom_range(0, 99) == 0)
					sink_eager = !sink_eager;
				hold = sink_eager ? 0 : pick_stall();
				if (hold > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check every response transfer against the oldest prediction.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("response transfer with no request outstanding");
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				checked_count++;
				if (rsp_ch.read_data !== want.read_data) begin
					$error("read_data: expected %0d, got %0d", want.read_data, rsp_ch.read_data);
					fail_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_ch.entry_count);
					fail_count++;
				end
				if (rsp_ch.is_empty_flag !== want.is_empty_flag) begin
					$error("is_empty_flag: expected %0b, got %0b", want.is_empty_flag,
						rsp_ch.is_empty_flag);
					fail_count++;
				end
				if (rsp_ch.is_full_flag !== want.is_full_flag) begin
					$error("is_full_flag: expected %0b, got %0b", want.is_full_flag,
						rsp_ch.is_full_flag);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		int idle_cycles;
		if (!arst_n ||
			(req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles, %0d responses outstanding",
					idle_cycles, awaited_results.size());
				$display("tb_positional_array_list_unit failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int sent;
		int extra;
		int left;
		int r;
		phase_t phase;
		pal_op_t op;

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = OP_READ;
		req_ch.pos   = '0;
		req_ch.item  = '0;
		shadow_len   = 0;
		fail_count   = 0;
		checked_count = 0;
		badpos_tally = 0;
		full_tally   = 0;
		at_capacity_tally = 0;
		sender_eager = 1'b0;
		sink_eager   = 1'b0;
		squeeze_done = 1'b0;
		foreach (op_tally[i])
			op_tally[i] = 0;

		// Edge cases: empty list, extreme words, end positions, bad positions.
		row_known(OP_READ,   7'd0,   32'sd0, 32'sd0, STAT_BADPOS, 8'd0, 1'b1, 1'b0);
		row_known(OP_DELETE, 7'd0,   32'sd0, 32'sd0, STAT_BADPOS, 8'd0, 1'b1, 1'b0);
		row_known(OP_INSERT, 7'd1,   32'sd5, 32'sd0, STAT_BADPOS, 8'd0, 1'b1, 1'b0);
		row_known(OP_READ,   7'd127, 32'sd0, 32'sd0, STAT_BADPOS, 8'd0, 1'b1, 1'b0);
		row_known(OP_INSERT, 7'd0,   32'sh8000_0000, 32'sd0, STAT_DONE, 8'd1, 1'b0, 1'b0);
		row_known(OP_APPEND, 7'd127, 32'sh7FFF_FFFF, 32'sd0, STAT_DONE, 8'd2, 1'b0, 1'b0);
		row_known(OP_READ,   7'd0,   32'sd0, 32'sh8000_0000, STAT_DONE, 8'd2, 1'b0, 1'b0);
		row_known(OP_READ,   7'd1,   32'sd0, 32'sh7FFF_FFFF, STAT_DONE, 8'd2, 1'b0, 1'b0);
		row_known(OP_READ,   7'd2,   32'sd0, 32'sd0, STAT_BADPOS, 8'd2, 1'b0, 1'b0);
		row_pred(OP_INSERT, 7'd1, -32'sd1);            // shift the tail up
		row_pred(OP_INSERT, 7'd3, 32'sh5555_5555);     // position equal to count appends
		row_pred(OP_INSERT, 7'd0, 32'shAAAA_AAAA);     // shift everything
		row_pred(OP_READ,   7'd1, 32'sd0);
		row_pred(OP_READ,   7'd2, 32'sd0);
		row_pred(OP_READ,   7'd3, 32'sd0);
		row_pred(OP_READ,   7'd4, 32'sd0);
		row_pred(OP_DELETE, 7'd2, 32'sd0);             // middle, shift down
		row_pred(OP_DELETE, 7'd3, 32'sd0);             // last entry
		row_pred(OP_DELETE, 7'd0, 32'sd0);
		row_pred(OP_READ,   7'd5, 32'sd0);
		row_known(OP_DELETE, 7'd127, 32'sd0, 32'sd0, STAT_BADPOS, 8'd2, 1'b0, 1'b0);
		row_pred(OP_DELETE, 7'd0, 32'sd0);
		row_pred(OP_DELETE, 7'd0, 32'sd0);             // back to empty
		row_pred(OP_APPEND, 7'd0, 32'sd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i])
			send_request(stim_table[i].op, stim_table[i].pos, stim_table[i].word,
				stim_table[i].known, stim_table[i].want);

		// Random phases. Fill runs past capacity to draw full rejections,
		// drain runs past empty to draw bad positions.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			phase = phase_t'($urandom_range(0, 2));
			sender_eager = ($urandom_range(0, 3) == 0);
			case (phase)
				PH_FILL: begin
					extra = $urandom_range(1, 4);
					while (extra > 0) begin
						r = $urandom_range(0, 99);
						op = (r < 45) ? OP_APPEND : (r < 85) ? OP_INSERT :
							(r < 93) ? OP_READ : OP_DELETE;
						if (shadow_len == CAPACITY)
							extra--;
						send_random(op);
						sent++;
					end
				end
				PH_DRAIN: begin
					extra = $urandom_range(1, 3);
					while (extra > 0) begin
						r = $urandom_range(0, 99);
						op = (r < 75) ? OP_DELETE : (r < 90) ? OP_READ :
							(r < 95) ? OP_INSERT : OP_APPEND;
						if (shadow_len == 0)
							extra--;
						send_random(op);
						sent++;
					end
				end
				default: begin
					left = $urandom_range(20, 60);
					repeat (left) begin
						send_random(pal_op_t'($urandom_range(0, 3)));
						sent++;
					end
				end
			endcase
		end

		// Drop valid in the step of the last request transfer, then drain.
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d requests: %0d reads, %0d appends, %0d inserts, %0d deletes",
			op_tally[OP_READ] + op_tally[OP_APPEND] + op_tally[OP_INSERT] + op_tally[OP_DELETE],
			op_tally[OP_READ], op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_DELETE]);
		$display("%0d bad positions, %0d full rejections, %0d requests at capacity, %0d checked",
			badpos_tally, full_tally, at_capacity_tally, checked_count);
		if (fail_count == 0)
			$display("tb_positional_array_list_unit passed");
		else
			$display("tb_positional_array_list_unit failed");
		$finish;
	end

endmodule
